// ===== rtl/cbm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_pkg
// Types and constants shared by the cartridge bank mapper modules.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int unsigned PatternWindows = 8;
  localparam int unsigned WinIdxW        = 3;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned TargetW  = 3;
  localparam int unsigned OffsetW  = 26;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // access kinds
  localparam logic [ActionW-1:0] ActCpuWrite = 2'd0;
  localparam logic [ActionW-1:0] ActCpuRead  = 2'd1;
  localparam logic [ActionW-1:0] ActPpuRead  = 2'd2;

  // target memories
  localparam logic [TargetW-1:0] TgtNone      = 3'd0;
  localparam logic [TargetW-1:0] TgtPrgRom    = 3'd1;
  localparam logic [TargetW-1:0] TgtWorkRam   = 3'd2;
  localparam logic [TargetW-1:0] TgtChrRom    = 3'd3;
  localparam logic [TargetW-1:0] TgtNametable = 3'd4;

  // nametable mirroring
  localparam logic [1:0] MirLower      = 2'd0;
  localparam logic [1:0] MirUpper      = 2'd1;
  localparam logic [1:0] MirVertical   = 2'd2;
  localparam logic [1:0] MirHorizontal = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPrgMask     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgChrMask     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWramPresent = 2'd2;

  // mapper register addresses
  localparam logic [11:0]      RegChrPage = 12'hC00;
  localparam logic [AddrW-1:0] RegPrgBank = 16'hC010;
  localparam logic [AddrW-1:0] RegMirror  = 16'hC014;

  localparam logic [7:0]  PrgMaskReset = 8'd15;
  localparam logic [15:0] ChrMaskReset = 16'd255;

  typedef struct packed {
    logic [7:0]  prg_bank_mask;
    logic [15:0] chr_bank_mask;
    logic        wram_present;
    logic [7:0]  program_bank;
    logic [1:0]  mirror_mode;
  } cbm_state_t;

  typedef struct packed {
    logic [TargetW-1:0] target;
    logic [OffsetW-1:0] offset;
    logic               page;
  } cbm_result_t;

endpackage
`default_nettype wire

// ===== rtl/cbm_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_regs
// Configuration registers, pattern bank registers, program bank and
// mirroring mode. CPU register writes are decoded here.
// ----------------------------------------------------------------------------
module cbm_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cbm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         wr_en_i,
  input  wire logic [cbm_pkg::AddrW-1:0]    wr_addr_i,
  input  wire logic [cbm_pkg::DataW-1:0]    wr_data_i,
  input  wire logic [cbm_pkg::WinIdxW-1:0]  win_idx_i,
  output logic      [15:0]                  win_bank_o,
  output cbm_pkg::cbm_state_t               state_o
);

  logic [15:0] pat_bank_q [cbm_pkg::PatternWindows];
  logic [15:0] pat_bank_d [cbm_pkg::PatternWindows];
  logic [7:0]  prg_mask_q, prg_mask_d;
  logic [15:0] chr_mask_q, chr_mask_d;
  logic        wram_q, wram_d;
  logic [7:0]  prg_bank_q, prg_bank_d;
  logic [1:0]  mirror_q, mirror_d;

  logic                        chr_hit;
  logic [cbm_pkg::WinIdxW-1:0] chr_win;

  // C000-C003 / C008-C00B low bytes, C004-C007 / C00C-C00F high bytes
  assign chr_hit = wr_en_i && (wr_addr_i[15:4] == cbm_pkg::RegChrPage);
  assign chr_win = {wr_addr_i[3], wr_addr_i[1:0]};

  always_comb begin
    for (int i = 0; i < cbm_pkg::PatternWindows; i++) begin
      pat_bank_d[i] = pat_bank_q[i];
    end
    if (chr_hit) begin
      if (wr_addr_i[2]) begin
        pat_bank_d[chr_win] = {wr_data_i, pat_bank_q[chr_win][7:0]};
      end else begin
        pat_bank_d[chr_win] = {pat_bank_q[chr_win][15:8], wr_data_i};
      end
    end
  end

  always_comb begin
    prg_bank_d = prg_bank_q;
    mirror_d   = mirror_q;
    if (wr_en_i && (wr_addr_i == cbm_pkg::RegPrgBank)) begin
      prg_bank_d = wr_data_i;
    end
    if (wr_en_i && (wr_addr_i == cbm_pkg::RegMirror)) begin
      mirror_d = wr_data_i[0] ? cbm_pkg::MirHorizontal : cbm_pkg::MirVertical;
    end
  end

  always_comb begin
    prg_mask_d = prg_mask_q;
    chr_mask_d = chr_mask_q;
    wram_d     = wram_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cbm_pkg::CfgPrgMask:     prg_mask_d = cfg_data_i[7:0];
        cbm_pkg::CfgChrMask:     chr_mask_d = cfg_data_i;
        cbm_pkg::CfgWramPresent: wram_d     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cbm_pkg::PatternWindows; i++) begin
        pat_bank_q[i] <= '0;
      end
      prg_mask_q <= cbm_pkg::PrgMaskReset;
      chr_mask_q <= cbm_pkg::ChrMaskReset;
      wram_q     <= 1'b0;
      prg_bank_q <= '0;
      mirror_q   <= cbm_pkg::MirLower;
    end else begin
      for (int i = 0; i < cbm_pkg::PatternWindows; i++) begin
        pat_bank_q[i] <= pat_bank_d[i];
      end
      prg_mask_q <= prg_mask_d;
      chr_mask_q <= chr_mask_d;
      wram_q     <= wram_d;
      prg_bank_q <= prg_bank_d;
      mirror_q   <= mirror_d;
    end
  end

  assign win_bank_o = pat_bank_q[win_idx_i];

  always_comb begin
    state_o.prg_bank_mask = prg_mask_q;
    state_o.chr_bank_mask = chr_mask_q;
    state_o.wram_present  = wram_q;
    state_o.program_bank  = prg_bank_q;
    state_o.mirror_mode   = mirror_q;
  end

endmodule
`default_nettype wire

// ===== rtl/cbm_xlate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cbm_xlate
// Address translation for one access: picks the target memory and builds
// the byte offset, or the nametable page and offset.
// ----------------------------------------------------------------------------
module cbm_xlate (
  input  wire logic [cbm_pkg::ActionW-1:0] action_i,
  input  wire logic [cbm_pkg::AddrW-1:0]   addr_i,
  input  wire cbm_pkg::cbm_state_t         state_i,
  input  wire logic [15:0]                 win_bank_i,
  output logic      [cbm_pkg::WinIdxW-1:0] win_idx_o,
  output cbm_pkg::cbm_result_t             result_o
);

  logic        in_ram;
  logic [13:0] ppu_addr;
  logic [7:0]  prg_bank;
  logic [15:0] chr_bank;
  logic        nt_page;

  assign in_ram    = state_i.wram_present && (addr_i[15:13] == 3'b011);
  assign ppu_addr  = addr_i[13:0];
  assign win_idx_o = ppu_addr[12:10];
  assign prg_bank  = state_i.program_bank & state_i.prg_bank_mask;
  assign chr_bank  = win_bank_i & state_i.chr_bank_mask;

  always_comb begin
    case (state_i.mirror_mode)
      cbm_pkg::MirLower:    nt_page = 1'b0;
      cbm_pkg::MirUpper:    nt_page = 1'b1;
      cbm_pkg::MirVertical: nt_page = ppu_addr[10];
      default:              nt_page = ppu_addr[11];
    endcase
  end

  always_comb begin
    result_o.target = cbm_pkg::TgtNone;
    result_o.offset = '0;
    result_o.page   = 1'b0;
    case (action_i)
      cbm_pkg::ActCpuWrite: begin
        if (in_ram) begin
          result_o.target = cbm_pkg::TgtWorkRam;
          result_o.offset = {13'd0, addr_i[12:0]};
        end
      end
      cbm_pkg::ActCpuRead: begin
        if (in_ram) begin
          result_o.target = cbm_pkg::TgtWorkRam;
          result_o.offset = {13'd0, addr_i[12:0]};
        end else if (addr_i[15:14] == 2'b10) begin
          result_o.target = cbm_pkg::TgtPrgRom;
          result_o.offset = {4'd0, prg_bank, addr_i[13:0]};
        end else if (addr_i[15:14] == 2'b11) begin
          // upper window is pinned to the last bank
          result_o.target = cbm_pkg::TgtPrgRom;
          result_o.offset = {4'd0, state_i.prg_bank_mask, addr_i[13:0]};
        end
      end
      cbm_pkg::ActPpuRead: begin
        if (!ppu_addr[13]) begin
          result_o.target = cbm_pkg::TgtChrRom;
          result_o.offset = {chr_bank, ppu_addr[9:0]};
        end else if (ppu_addr[13:8] != 6'h3F) begin
          result_o.target = cbm_pkg::TgtNametable;
          result_o.offset = {16'd0, ppu_addr[9:0]};
          result_o.page   = nt_page;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/cartridge_bank_mapper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// Bank mapper for CPU and PPU accesses: register writes, program/work RAM
// and pattern/nametable address translation.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  in       | in_valid_i/in_stall_o  | in_action_i, in_address_i, in_data_i
//  out      | out_valid_o/out_stall_i| out_target_o, out_offset_o, out_page_o
//  cfg      | cfg_we_i               | cfg_index_i, cfg_data_i
//
//  One item per cycle unless the output stalls; an item passes through the input register, then the result register.
//  Translation and register update happen in the same cycle, after the input register.
//  Reset: pattern banks and program bank zero, single-screen lower mirroring,
//  masks 15 / 255, no work RAM.
//  A stalled result holds; in_stall_o is high in the same cycle while both
//  registers hold an item and out_stall_i is high.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cbm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cbm_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [cbm_pkg::ActionW-1:0]  in_action_i,
  input  wire logic [cbm_pkg::AddrW-1:0]    in_address_i,
  input  wire logic [cbm_pkg::DataW-1:0]    in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [cbm_pkg::TargetW-1:0]  out_target_o,
  output logic      [cbm_pkg::OffsetW-1:0]  out_offset_o,
  output logic                              out_page_o
);

  logic                        s1_valid_q, s1_valid_d;
  logic [cbm_pkg::ActionW-1:0] s1_action_q;
  logic [cbm_pkg::AddrW-1:0]   s1_addr_q;
  logic [cbm_pkg::DataW-1:0]   s1_data_q;
  logic                        out_valid_q, out_valid_d;
  cbm_pkg::cbm_result_t        out_result_q;

  logic                        advance;
  logic                        in_accept;
  logic                        reg_wr;
  logic [cbm_pkg::WinIdxW-1:0] win_idx;
  logic [15:0]                 win_bank;
  cbm_pkg::cbm_state_t         state;
  cbm_pkg::cbm_result_t        result;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  // state changes as the item leaves the input register, so later items
  // always see it
  assign reg_wr     = advance && (s1_action_q == cbm_pkg::ActCpuWrite);

  cbm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_i     (reg_wr),
    .wr_addr_i   (s1_addr_q),
    .wr_data_i   (s1_data_q),
    .win_idx_i   (win_idx),
    .win_bank_o  (win_bank),
    .state_o     (state)
  );

  cbm_xlate u_xlate (
    .action_i   (s1_action_q),
    .addr_i     (s1_addr_q),
    .state_i    (state),
    .win_bank_i (win_bank),
    .win_idx_o  (win_idx),
    .result_o   (result)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_action_q <= in_action_i;
      s1_addr_q   <= in_address_i;
      s1_data_q   <= in_data_i;
    end
    if (advance) begin
      out_result_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_target_o = out_result_q.target;
  assign out_offset_o = out_result_q.offset;
  assign out_page_o   = out_result_q.page;

`ifndef SYNTH
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_none_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_target_o == cbm_pkg::TgtNone)) |->
      ((out_offset_o == '0) && !out_page_o))
    else $error("empty result carries offset or page");

  a_page_only_nt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_page_o) |-> (out_target_o == cbm_pkg::TgtNametable))
    else $error("page set outside nametable access");

  a_wram_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_target_o == cbm_pkg::TgtWorkRam)) |->
      (out_offset_o[cbm_pkg::OffsetW-1:13] == '0))
    else $error("work RAM offset beyond 8KB");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("item lost between input and result register");
`endif

endmodule
`default_nettype wire
